/* rtl/base64_stream_decoder_unit_assert.svh */
// Assertion macros used by the decoder top-level module.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64SD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/b64sd_pkg.sv */
package b64sd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;
  localparam logic [15:0] LEN_FIELD_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LONG  = 2'd1,
    STATUS_UNALIGNED = 2'd2,
    STATUS_BAD_CHAR  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Everything one input word produces: up to three bytes and an optional status.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  nbytes;
    logic        has_status;
    status_e     status;
    logic [15:0] length;
  } rec_t;

  // Returns {in alphabet, six-bit value}; '=' is in the alphabet with value zero.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    begin
      r = '0;
      if (c inside {[8'h41:8'h5A]}) begin
        r = {1'b1, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
        r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
        r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
        r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
        r = {1'b1, 6'd63};
      end else if (c == PAD_CHAR) begin
        r = {1'b1, 6'd0};
      end
      return r;
    end
  endfunction

endpackage

/* rtl/b64sd_decode.sv */
module b64sd_decode #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         char_i,
  input  logic               end_i,
  input  logic [15:0]        max_len_i,
  output logic               push_o,
  output b64sd_pkg::rec_t    rec_o
);

  localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [17:0]            store_q, store_d;
  logic [1:0]             pos_q, pos_d;
  logic                   third_q, third_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic                   bad_q, bad_d;

  logic [6:0]             lookup;
  logic                   is_pad;
  logic [1:0]             nbytes;
  logic [LENGTH_BITS:0]   sum;
  logic [LENGTH_BITS-1:0] count_new;
  logic [CMP_W-1:0]       count_ext;

  assign lookup = b64sd_pkg::sextet_of(char_i);
  assign is_pad = (char_i == b64sd_pkg::PAD_CHAR);

  always_comb begin
    store_d = store_q;
    pos_d   = pos_q;
    third_d = third_q;
    nbytes  = 2'd0;
    if (pos_q != 2'd3) begin
      store_d = {store_q[11:0], lookup[5:0]};
      if (pos_q == 2'd2) begin
        third_d = is_pad;
      end
      pos_d = pos_q + 2'd1;
    end else begin
      // Padding only trims bytes in the group closed by the final character.
      nbytes  = 2'd3 - {1'b0, end_i & third_q} - {1'b0, end_i & is_pad};
      store_d = '0;
      pos_d   = 2'd0;
      third_d = 1'b0;
    end
  end

  assign sum       = {1'b0, count_q} + (LENGTH_BITS + 1)'(nbytes);
  assign count_new = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
  assign count_ext = CMP_W'(count_new);
  assign bad_d     = bad_q | ~lookup[6];

  always_comb begin
    rec_o.triple     = {store_q, lookup[5:0]};
    rec_o.nbytes     = nbytes;
    rec_o.has_status = end_i;
    rec_o.length     = (count_ext > CMP_W'(b64sd_pkg::LEN_FIELD_MAX)) ?
                       b64sd_pkg::LEN_FIELD_MAX : count_ext[15:0];
    if (pos_d != 2'd0) begin
      rec_o.status = b64sd_pkg::STATUS_UNALIGNED;
    end else if (bad_d) begin
      rec_o.status = b64sd_pkg::STATUS_BAD_CHAR;
    end else if (count_ext > CMP_W'(max_len_i)) begin
      rec_o.status = b64sd_pkg::STATUS_TOO_LONG;
    end else begin
      rec_o.status = b64sd_pkg::STATUS_OK;
    end
  end

  assign push_o  = accept_i & ((pos_q == 2'd3) | end_i);
  assign count_d = count_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      pos_q   <= '0;
      third_q <= 1'b0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      if (end_i) begin
        store_q <= '0;
        pos_q   <= '0;
        third_q <= 1'b0;
        count_q <= '0;
        bad_q   <= 1'b0;
      end else begin
        store_q <= store_d;
        pos_q   <= pos_d;
        third_q <= third_d;
        count_q <= count_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

/* rtl/b64sd_out_queue.sv */
module b64sd_out_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64sd_pkg::rec_t rec_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            kind_o,
  output logic [7:0]      byte_o,
  output logic [1:0]      status_o,
  output logic [15:0]     length_o,
  output logic            last_o
);

  b64sd_pkg::rec_t rec_q [2];
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      idx_q;
  logic [2:0]      total;
  logic            is_byte;
  logic            take;
  logic            pop;
  logic            wr_idx;

  assign total   = {1'b0, rec_q[0].nbytes} + {2'b00, rec_q[0].has_status};
  assign is_byte = (idx_q < rec_q[0].nbytes);
  assign valid_o = (cnt_q != 2'd0);
  assign last_o  = ({1'b0, idx_q} == (total - 3'd1));
  assign take    = valid_o & ready_i;
  assign pop     = take & last_o;
  assign full_o  = (cnt_q == 2'd2);
  assign wr_idx  = (cnt_q == 2'd1) & ~pop;

  always_comb begin
    kind_o   = is_byte ? b64sd_pkg::KIND_DATA : b64sd_pkg::KIND_STATUS;
    status_o = is_byte ? 2'd0 : rec_q[0].status;
    length_o = is_byte ? 16'd0 : rec_q[0].length;
    case (idx_q)
      2'd0:    byte_o = rec_q[0].triple[23:16];
      2'd1:    byte_o = rec_q[0].triple[15:8];
      2'd2:    byte_o = rec_q[0].triple[7:0];
      default: byte_o = 8'd0;
    endcase
    if (!is_byte) begin
      byte_o = 8'd0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end else if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // The head slot drains first; a new record lands behind whatever remains.
  // A push never meets a full queue, so a push with a pop always refills the head.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rec_q[wr_idx] <= rec_i;
    end else if (pop) begin
      rec_q[0] <= rec_q[1];
    end
  end

endmodule

/* rtl/base64_stream_decoder_unit.sv */
// Results of an input word are registered in the output queue before they reach the output.
// Throughput: one input word per cycle and, while m_axis_tready is high, one result word per
// cycle, drained from a two-record output queue that stalls the input only when both records
// are held; a word that closes a group yields up to three bytes, the final word up to four results.
// Reset clears the group state, the byte count and the queue, and sets the length limit to 256.
module base64_stream_decoder_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status,
                                      // [25:10] decoded_length, [31:26] zero
  output logic        m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]     max_len_q;
  logic            accept;
  logic            push;
  logic            full;
  b64sd_pkg::rec_t rec;
  logic [7:0]      out_byte;
  logic [1:0]      out_status;
  logic [15:0]     out_length;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= b64sd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  b64sd_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .max_len_i(max_len_q),
    .push_o   (push),
    .rec_o    (rec)
  );

  b64sd_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (m_axis_tuser),
    .byte_o  (out_byte),
    .status_o(out_status),
    .length_o(out_length),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_length, out_status, out_byte};

`include "base64_stream_decoder_unit_assert.svh"

  // The end status is always the closing result of its input word.
  `B64SD_ASSERT_NOW(a_status_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
    "end status word without tlast")
  // A data byte word carries no status and no length.
  `B64SD_ASSERT_NOW(a_data_fields_clear, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata[31:8] == 24'd0, "data byte word with status or length bits set")
  // The final character always leaves at least its status waiting at the output.
  `B64SD_ASSERT_NEXT(a_end_gives_result, s_axis_tvalid && s_axis_tready && s_axis_tlast,
    m_axis_tvalid, "final character accepted but no result follows")

endmodule
